>>> src/lrr_pkg.sv
`default_nettype none

package lrr_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned DIV_STEPS   = 32;

    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;

    localparam logic [2:0] OP_RAW     = 3'd0;
    localparam logic [2:0] OP_UBOUND  = 3'd1;
    localparam logic [2:0] OP_URANGE  = 3'd2;
    localparam logic [2:0] OP_SBOUND  = 3'd3;
    localparam logic [2:0] OP_SRANGE  = 3'd4;
    localparam logic [2:0] OP_RESTART = 3'd5;

    localparam logic [1:0] KIND_DIRECT  = 2'd0;
    localparam logic [1:0] KIND_STEP    = 2'd1;
    localparam logic [1:0] KIND_DRAW    = 2'd2;
    localparam logic [1:0] KIND_RESTART = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic        use_div;
        logic [32:0] divisor;
        logic [31:0] addend;
        logic        err;
    } job_t;

endpackage

`default_nettype wire

>>> src/lcg_ranged_random_unit.sv
// Channel   Direction  tdata                                    tuser
// s_        in         [31:0] low_bound, [63:32] high_bound     [2:0] op
// m_        out        [31:0] value                             [0] div_error
// seed_     in         seed_we strobes seed_wdata into the seed and the generator state
//
// A word that needs a remainder passes through the back-end states in order: S_IDLE takes it
// from the queue and steps the generator, S_DIV runs the one-bit-per-cycle restoring
// remainder loop, and S_OUT loads the output register once it is free. Other words skip S_DIV.
// Reset empties the queue and the output register and sets seed and state to zero.
// Two queued words let the input keep accepting while the back end divides or stalls.
`default_nettype none

module lcg_ranged_random_unit #(
    parameter int unsigned QUEUE_DEPTH = lrr_pkg::QUEUE_DEPTH
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_we,
    input  wire logic [31:0] seed_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [31:0] low_bound, [63:32] high_bound
    input  wire logic [63:0] s_tdata,
    // [2:0] op
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] value
    output logic [31:0]      m_tdata,
    // [0] div_error
    output logic             m_tuser
);

    lrr_pkg::job_t front_job;
    lrr_pkg::job_t head_job;
    logic          full;
    logic          empty;
    logic          pop;

    assign s_tready = !full;

    lrr_front u_front (
        .op         (s_tuser),
        .low_bound  (s_tdata[31:0]),
        .high_bound (s_tdata[63:32]),
        .job        (front_job)
    );

    lrr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (s_tvalid),
        .push_job (front_job),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_job (head_job)
    );

    lrr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (seed_we),
        .seed_wdata (seed_wdata),
        .empty      (empty),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

>>> src/lrr_front.sv
`default_nettype none

module lrr_front (
    input  wire logic [2:0]  op,
    input  wire logic [31:0] low_bound,
    input  wire logic [31:0] high_bound,
    output lrr_pkg::job_t    job
);

    logic [33:0] udiff;
    logic [33:0] sdiff;
    logic [33:0] smag;
    logic [31:0] hmag;

    assign udiff = {2'b00, high_bound} + 34'd1 - {2'b00, low_bound};
    assign sdiff = {{2{high_bound[31]}}, high_bound} + 34'd1
                 - {{2{low_bound[31]}}, low_bound};
    assign smag  = sdiff[33] ? (34'd0 - sdiff) : sdiff;
    assign hmag  = high_bound[31] ? (32'd0 - high_bound) : high_bound;

    always_comb
    begin
        job = '0;
        case (op)
            lrr_pkg::OP_RAW:
            begin
                job.kind = lrr_pkg::KIND_DRAW;
            end
            lrr_pkg::OP_UBOUND:
            begin
                if (high_bound != 32'd0)
                begin
                    job.kind    = lrr_pkg::KIND_DRAW;
                    job.use_div = 1'b1;
                    job.divisor = {1'b0, high_bound};
                    job.addend  = 32'd1;
                end
            end
            lrr_pkg::OP_URANGE:
            begin
                job.addend = low_bound;
                if (high_bound == low_bound)
                begin
                    job.kind = lrr_pkg::KIND_DIRECT;
                end
                else if (udiff == 34'd0)
                begin
                    job.kind = lrr_pkg::KIND_STEP;
                    job.err  = 1'b1;
                end
                else
                begin
                    // A negative span sets udiff[33] and turns the remainder off, so the draw passes unchanged.
                    job.kind    = lrr_pkg::KIND_DRAW;
                    job.use_div = !udiff[33];
                    job.divisor = udiff[32:0];
                end
            end
            lrr_pkg::OP_SBOUND:
            begin
                if (high_bound != 32'd0)
                begin
                    job.kind    = lrr_pkg::KIND_DRAW;
                    job.use_div = 1'b1;
                    job.divisor = {1'b0, hmag};
                    job.addend  = 32'd1;
                end
            end
            lrr_pkg::OP_SRANGE:
            begin
                job.addend = low_bound;
                if (high_bound == low_bound)
                begin
                    job.kind = lrr_pkg::KIND_DIRECT;
                end
                else if (sdiff == 34'd0)
                begin
                    job.kind = lrr_pkg::KIND_STEP;
                    job.err  = 1'b1;
                end
                else
                begin
                    job.kind    = lrr_pkg::KIND_DRAW;
                    job.use_div = 1'b1;
                    job.divisor = smag[32:0];
                end
            end
            lrr_pkg::OP_RESTART:
            begin
                job.kind = lrr_pkg::KIND_RESTART;
            end
            default:
            begin
                job.kind = lrr_pkg::KIND_DIRECT;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> src/lrr_queue.sv
`default_nettype none

module lrr_queue #(
    parameter int unsigned DEPTH = lrr_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lrr_pkg::job_t push_job,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output lrr_pkg::job_t      head_job
);

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    lrr_pkg::job_t   mem_reg [DEPTH];
    logic [IW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [IW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> src/lrr_back.sv
`default_nettype none

module lrr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          seed_we,
    input  wire logic [31:0]   seed_wdata,
    input  wire logic          empty,
    input  wire lrr_pkg::job_t head_job,
    output logic               pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [31:0]        m_tdata,
    output logic               m_tuser
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    localparam int unsigned CNT_W = $clog2(lrr_pkg::DIV_STEPS);

    logic [1:0]       state_reg, state_next;
    logic [31:0]      current_reg, current_next;
    logic [31:0]      seed_reg, seed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;

    lrr_pkg::job_t    job_reg, job_next;
    logic [31:0]      dividend_reg, dividend_next;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      res_reg, res_next;
    logic [31:0]      out_value_reg, out_value_next;
    logic             out_err_reg, out_err_next;

    logic [31:0]      product;
    logic [31:0]      lcg_next;
    logic [33:0]      trial;
    logic [33:0]      rem_shift;

    assign product   = current_reg * lrr_pkg::LCG_MUL;
    assign lcg_next  = product + lrr_pkg::LCG_ADD;
    assign trial     = {rem_reg, dividend_reg[31]};
    assign rem_shift = (trial >= {1'b0, job_reg.divisor})
                     ? trial - {1'b0, job_reg.divisor} : trial;

    assign pop      = (state_reg == S_IDLE) && !empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        current_next   = current_reg;
        seed_next      = seed_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        job_next       = job_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        res_next       = res_reg;
        out_value_next = out_value_reg;
        out_err_next   = out_err_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    job_next   = head_job;
                    res_next   = 32'd0;
                    state_next = S_OUT;
                    case (head_job.kind)
                        lrr_pkg::KIND_RESTART:
                        begin
                            current_next = seed_reg;
                            res_next     = seed_reg;
                        end
                        lrr_pkg::KIND_STEP:
                        begin
                            current_next = lcg_next;
                        end
                        lrr_pkg::KIND_DRAW:
                        begin
                            current_next = lcg_next;
                            if (head_job.use_div)
                            begin
                                dividend_next = lcg_next;
                                rem_next      = '0;
                                count_next    = '0;
                                state_next    = S_DIV;
                            end
                            else
                            begin
                                res_next = lcg_next;
                            end
                        end
                        default:
                        begin
                            res_next = 32'd0;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                rem_next      = rem_shift[32:0];
                dividend_next = {dividend_reg[30:0], 1'b0};
                count_next    = count_reg + 1'b1;
                if (count_reg == CNT_W'(lrr_pkg::DIV_STEPS - 1))
                begin
                    res_next   = rem_shift[31:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg + job_reg.addend;
                    out_err_next   = job_reg.err;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (seed_we)
        begin
            seed_next    = seed_wdata;
            current_next = seed_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            current_reg   <= 32'd0;
            seed_reg      <= 32'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            current_reg   <= current_next;
            seed_reg      <= seed_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg       <= job_next;
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
        out_err_reg   <= out_err_next;
    end

endmodule

`default_nettype wire

>>> src/lrr_checker.sv
`default_nettype none

module lrr_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);

    // A stalled result word stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // Reset leaves nothing to deliver and room to accept.
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && s_tready)
        else $error("reset did not clear the output or the queue");

    // The input can only fill up right after it took a word.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(s_tvalid && s_tready))
        else $error("input ready dropped without an accepted word");

endmodule

bind lcg_ranged_random_unit lrr_checker u_lrr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
